>>> rtl/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and codes for the double-ended queue: operation codes,
// status codes and the command passed from the front end to the back end.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int IO_W     = 32;
  localparam int STATUS_W = 2;

  // input mode codes
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRAVERSE   = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

  // command queue between front and back
  localparam int CQ_DEPTH = 2;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_TRAVERSE
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [IO_W-1:0] data;
  } cmd_t;

endpackage

>>> rtl/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/dq_front.sv
// ----------------------------------------------------------------------------
// dq_front
// Input side: accepts beats, decodes the mode into a command and holds it
// in a short queue for the back end. Unused mode codes are dropped.
// ----------------------------------------------------------------------------
module dq_front
  import dq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IO_W-1:0]   s_data,
  input  logic [MODE_W-1:0] s_mode,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  cmd_t             q [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr;
  logic [CQ_AW-1:0] rd_ptr;
  logic [CQ_AW:0]   cnt;

  logic known;
  op_t  op_dec;
  logic push;
  logic pop;

  always_comb begin
    known  = 1'b1;
    op_dec = OP_TRAVERSE;
    unique case (s_mode)
      MODE_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      MODE_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      MODE_POP_FRONT:  op_dec = OP_POP_FRONT;
      MODE_POP_BACK:   op_dec = OP_POP_BACK;
      MODE_TRAVERSE:   op_dec = OP_TRAVERSE;
      default:         known  = 1'b0;
    endcase
  end

  assign s_tready  = (cnt != (CQ_AW+1)'(CQ_DEPTH));
  assign cmd_valid = (cnt != '0);
  assign cmd       = q[rd_ptr];
  assign push      = s_tvalid && s_tready && known;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{op: op_dec, data: s_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

>>> rtl/dq_back.sv
// ----------------------------------------------------------------------------
// dq_back
// Execution side: keeps the front index and element count, drives the
// element RAM and loads the output register; it takes no new command while a RAM read is still to be loaded.
// ----------------------------------------------------------------------------
module dq_back
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  cmd_t                cmd,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [IO_W-1:0]     m_tdata,
  output logic [STATUS_W-1:0] m_tuser,
  output logic                m_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t state, state_next;
  logic [AW-1:0] front, front_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] idx, idx_next;
  logic          trav, trav_next;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic                  re;
  logic [AW-1:0]         raddr;
  logic [DATA_WIDTH-1:0] rdata;

  logic                out_free;
  logic                load;
  logic [IO_W-1:0]     ld_data;
  logic [STATUS_W-1:0] ld_status;
  logic                ld_last;

  logic [AW-1:0] front_dec;
  logic          is_full;
  logic          is_empty;
  logic          trav_last;

  // position front + off, wrapped once at DEPTH
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                         input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign out_free  = !m_tvalid || m_tready;
  assign front_dec = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign trav_last = (CW'(idx) == count - 1'b1);

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (DATA_WIDTH'(cmd.data)),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    idx_next   = idx;
    trav_next  = trav;
    cmd_ready  = 1'b0;
    we         = 1'b0;
    waddr      = front_dec;
    re         = 1'b0;
    raddr      = front;
    load       = 1'b0;
    ld_data    = '0;
    ld_status  = ST_OK;
    ld_last    = 1'b1;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          unique case (cmd.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              load = 1'b1;
              if (is_full) begin
                ld_status = ST_OVERFLOW;
              end else begin
                we         = 1'b1;
                count_next = count + 1'b1;
                if (cmd.op == OP_PUSH_FRONT) begin
                  waddr      = front_dec;
                  front_next = front_dec;
                end else begin
                  waddr = slot(front, count[AW-1:0]);
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (is_empty) begin
                load      = 1'b1;
                ld_status = ST_UNDERFLOW;
              end else begin
                re         = 1'b1;
                count_next = count - 1'b1;
                trav_next  = 1'b0;
                state_next = S_READ;
                if (cmd.op == OP_POP_FRONT) begin
                  raddr      = front;
                  front_next = slot(front, AW'(1));
                end else begin
                  raddr = slot(front, AW'(count - 1'b1));
                end
              end
            end
            OP_TRAVERSE: begin
              if (is_empty) begin
                load      = 1'b1;
                ld_status = ST_EMPTY;
              end else begin
                re         = 1'b1;
                raddr      = front;
                idx_next   = '0;
                trav_next  = 1'b1;
                state_next = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (out_free) begin
          load    = 1'b1;
          ld_data = IO_W'(rdata);
          ld_last = !trav || trav_last;
          if (ld_last) begin
            state_next = S_IDLE;
          end else begin
            // fetch the next element while this one goes out
            idx_next = idx + 1'b1;
            re       = 1'b1;
            raddr    = slot(front, idx + 1'b1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      front    <= '0;
      count    <= '0;
      idx      <= '0;
      trav     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      idx   <= idx_next;
      trav  <= trav_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= ld_data;
      m_tuser <= ld_status;
      m_tlast <= ld_last;
    end
  end

endmodule

>>> rtl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue in a circular RAM: push and pop at either end,
// and traverse from front to back with the final element marked.
// ----------------------------------------------------------------------------
// channel | dir | tdata            | tuser       | tlast
// s_*     | in  | data_in [31:0]   | mode [2:0]  | -
// m_*     | out | data_out [31:0]  | status[1:0] | last
//
// A push, a failed pop and an empty traverse give their result in the cycle
// after leaving the command queue; a pop goes through the registered RAM
// read, then the output register. A traverse gives one element per cycle
// from the RAM read port unless the output stalls. A two-entry command
// queue lets the input side keep accepting beats while the output register
// stalls. Reset clears the indices and count; RAM contents stay as they are.
// ----------------------------------------------------------------------------
module double_ended_queue
  import dq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IO_W-1:0]     s_tdata,   // data_in
  input  logic [MODE_W-1:0]   s_tuser,   // mode
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [IO_W-1:0]     m_tdata,   // data_out
  output logic [STATUS_W-1:0] m_tuser,   // status
  output logic                m_tlast
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  dq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_data    (s_tdata),
    .s_mode    (s_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  dq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
